// ----- rtl/core/lbm_pkg.sv -----
// Shared widths, register indexes, constants and the result type of the level meter.
// Used by the result and configuration interfaces and by the front end, back end and top module.
package lbm_pkg;

	localparam int LAMP_W     = 5;
	localparam int FALL_W     = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_LAMP_COUNT = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FALL_STEP  = 2'd1;

	localparam logic [LAMP_W-1:0] LAMP_COUNT_RST = 5'd16;
	localparam logic [LAMP_W-1:0] MIN_LAMPS      = 5'd6;
	localparam logic [FALL_W-1:0] FALL_STEP_RST  = 16'd3932;

	// 2^24 * 20*log10(2) / 48, rounded.
	localparam int              DB_SCALE_W = 22;
	localparam logic [21:0]     DB_SCALE   = 22'd2104352;
	localparam int              DB_SHIFT   = 24;
	localparam longint unsigned FLOOR_DIV  = 64'd100000;

	typedef struct packed {
		logic [LAMP_W-1:0] lit_lamps;
		logic              changed;
		logic [LAMP_W-1:0] change_low;
		logic [LAMP_W-1:0] change_high;
	} lbm_result_t;

endpackage

// ----- rtl/core/lbm_samp_if.sv -----
// Sample channel of the level meter: valid/ready handshake and one amplitude.
// Depends on nothing but its width parameter.
interface lbm_samp_if #(parameter int AMP_BITS = 24) ();
	logic                valid;
	logic                ready;
	logic [AMP_BITS-1:0] amplitude;

	modport source(output valid, output amplitude, input ready);
	modport sink(input valid, input amplitude, output ready);
endinterface

// ----- rtl/core/lbm_res_if.sv -----
// Result channel of the level meter: valid/ready handshake and the lamp fields.
// Takes its widths from lbm_pkg.
interface lbm_res_if import lbm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LAMP_W-1:0] lit_lamps;
	logic              changed;
	logic [LAMP_W-1:0] change_low;
	logic [LAMP_W-1:0] change_high;

	modport source(output valid, output lit_lamps, output changed, output change_low,
		output change_high, input ready);
	modport sink(input valid, input lit_lamps, input changed, input change_low,
		input change_high, output ready);
endinterface

// ----- rtl/core/lbm_cfg_if.sv -----
// Configuration write channel of the level meter: valid/ready, register index and data.
// Takes its widths from lbm_pkg.
interface lbm_cfg_if import lbm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output addr, output data, input ready);
	modport sink(input valid, input addr, input data, output ready);
endinterface

// ----- rtl/core/lbm_front.sv -----
// Front end of the level meter: takes samples, flags silence and converts the
// amplitude to a normalized decibel level in a stalling pipeline. Uses lbm_pkg, lbm_samp_if.
module lbm_front import lbm_pkg::*; #(
	parameter int AMP_BITS   = 24,
	parameter int LEVEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lbm_samp_if.sink              samp,
	output logic                  lvl_valid,
	input  logic                  lvl_ready,
	output logic [LEVEL_BITS-1:0] lvl
);

	localparam int EW = $clog2(AMP_BITS);
	localparam longint unsigned FLOOR_MAX = (64'd1 << AMP_BITS) / FLOOR_DIV;
	localparam int NEG_W  = $clog2(AMP_BITS + 1) + LEVEL_BITS;
	localparam int PROD_W = NEG_W + DB_SCALE_W;
	localparam int DROP_W = PROD_W - DB_SHIFT + 1;

	logic adv;

	logic                v_s1, v_s2;
	logic [AMP_BITS-1:0] amp_s1, amp_s2;
	logic                sil_s1, sil_s2;
	logic [EW-1:0]       e_s2;
	logic [EW-1:0]       lead;
	logic [4:0]          sh;

	logic                  v_s[0:LEVEL_BITS];
	logic [31:0]           mant_s[0:LEVEL_BITS];
	logic [LEVEL_BITS-1:0] frac_s[0:LEVEL_BITS];
	logic [EW-1:0]         exp_s[0:LEVEL_BITS];
	logic                  sil_s[0:LEVEL_BITS];

	logic              v_s4, v_s5;
	logic              sil_s4, sil_s5;
	logic [NEG_W-1:0]  neg_s4, neg_d, span;
	logic [PROD_W-1:0] prod_s5;
	logic [PROD_W:0]   rnd_sum;
	logic [DROP_W-1:0] drop;
	logic [LEVEL_BITS-1:0] lvl_d;

	assign adv = !lvl_valid || lvl_ready;
	assign samp.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= samp.valid;
			v_s2 <= v_s1;
			v_s[0] <= v_s2;
		end
	end

	always_comb begin
		lead = '0;
		for (int i = 0; i < AMP_BITS; i++) begin
			if (amp_s1[i]) begin
				lead = EW'(i);
			end
		end
	end

	assign sh = 5'd31 - 5'(e_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			amp_s1 <= samp.amplitude;
			sil_s1 <= (64'(samp.amplitude) <= FLOOR_MAX);
			amp_s2 <= amp_s1;
			sil_s2 <= sil_s1;
			e_s2 <= lead;
			mant_s[0] <= 32'(amp_s2) << sh;
			frac_s[0] <= '0;
			exp_s[0] <= e_s2;
			sil_s[0] <= sil_s2;
		end
	end

	for (genvar k = 0; k < LEVEL_BITS; k++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] t;

		assign sq = mant_s[k] * mant_s[k];
		assign t  = sq[63:31];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				mant_s[k+1] <= t[32] ? t[32:1] : t[31:0];
				frac_s[k+1] <= {frac_s[k][LEVEL_BITS-2:0], t[32]};
				exp_s[k+1] <= exp_s[k];
				sil_s[k+1] <= sil_s[k];
			end
		end
	end

	always_comb begin
		span  = (NEG_W'(AMP_BITS) - NEG_W'(exp_s[LEVEL_BITS])) << LEVEL_BITS;
		neg_d = span - NEG_W'(frac_s[LEVEL_BITS]);
	end

	assign rnd_sum = (PROD_W+1)'(prod_s5) + ((PROD_W+1)'(1) << (DB_SHIFT - 1));
	assign drop    = rnd_sum[PROD_W:DB_SHIFT];

	always_comb begin
		if (sil_s5 || drop >= (DROP_W'(1) << LEVEL_BITS)) begin
			lvl_d = '0;
		end else if (drop == '0) begin
			lvl_d = '1;
		end else begin
			lvl_d = LEVEL_BITS'((DROP_W'(1) << LEVEL_BITS) - drop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			lvl_valid <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s[LEVEL_BITS];
			v_s5 <= v_s4;
			lvl_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s4 <= neg_d;
			sil_s4 <= sil_s[LEVEL_BITS];
			prod_s5 <= PROD_W'(neg_s4) * PROD_W'(DB_SCALE);
			sil_s5 <= sil_s4;
			lvl <= lvl_d;
		end
	end

endmodule

// ----- rtl/core/lbm_queue.sv -----
// Two-entry queue between the front end and the lamp logic of the level meter.
// Stand-alone; no package needed.
module lbm_queue #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q[0:DEPTH-1];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;
	logic            push, pop;

	assign push_ready = (cnt_q != CNTW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/core/lbm_back.sv -----
// Back end of the level meter: decay of the shown level, lamp count with hysteresis
// and the result register. Uses lbm_pkg and lbm_res_if.
module lbm_back import lbm_pkg::*; #(
	parameter int LEVEL_BITS = 16,
	parameter int MAX_LAMPS  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  lvl_valid,
	output logic                  lvl_ready,
	input  logic [LEVEL_BITS-1:0] lvl,
	input  logic [LAMP_W-1:0]     lamp_count,
	input  logic [FALL_W-1:0]     fall_step,
	lbm_res_if.source             res
);

	localparam int CW = (LEVEL_BITS > FALL_W) ? LEVEL_BITS : FALL_W;
	localparam int PW = LEVEL_BITS + LAMP_W;
	localparam int LAMP_TOP = (1 << LAMP_W) - 1;
	localparam logic [LAMP_W-1:0] LAMP_HI =
		LAMP_W'((MAX_LAMPS > LAMP_TOP) ? LAMP_TOP : MAX_LAMPS);
	localparam longint unsigned HYST_I = (3 * (64'd1 << LEVEL_BITS) + 5) / 10;
	localparam logic [PW:0] HYST = (PW+1)'(HYST_I);

	logic [LEVEL_BITS-1:0] shown_q, shown_d;
	logic [LAMP_W-1:0]     lamps_q;
	logic                  ov_q;
	lbm_result_t           res_q, res_d;

	logic [CW-1:0]     dec;
	logic [LAMP_W-1:0] count, prev_lit, after, up;
	logic [PW-1:0]     pos;
	logic [PW:0]       hsum;
	logic [LAMP_W:0]   dn;
	logic              pop;

	assign lvl_ready = !ov_q || res.ready;
	assign pop = lvl_valid && lvl_ready;

	always_comb begin
		dec = (CW'(fall_step) >= CW'(shown_q)) ? '0 : CW'(shown_q) - CW'(fall_step);
		if (lvl > shown_q) begin
			shown_d = lvl;
		end else if (dec > CW'(lvl)) begin
			shown_d = LEVEL_BITS'(dec);
		end else begin
			shown_d = lvl;
		end

		if (lamp_count < MIN_LAMPS) begin
			count = MIN_LAMPS;
		end else if (lamp_count > LAMP_HI) begin
			count = LAMP_HI;
		end else begin
			count = lamp_count;
		end

		pos  = PW'(shown_d) * PW'(count);
		up   = pos[PW-1:LEVEL_BITS];
		hsum = (PW+1)'(pos) + HYST;
		dn   = hsum[PW:LEVEL_BITS];
		prev_lit = (lamps_q > count) ? count : lamps_q;

		if (up > prev_lit) begin
			after = up;
		end else if (dn < (LAMP_W+1)'(prev_lit)) begin
			after = dn[LAMP_W-1:0];
		end else begin
			after = prev_lit;
		end

		res_d.lit_lamps   = after;
		res_d.changed     = (prev_lit != after);
		res_d.change_low  = (prev_lit < after) ? prev_lit : after;
		res_d.change_high = (prev_lit > after) ? prev_lit : after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
			lamps_q <= '0;
			ov_q <= 1'b0;
		end else if (pop) begin
			shown_q <= shown_d;
			lamps_q <= after;
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign res.valid       = ov_q;
	assign res.lit_lamps   = res_q.lit_lamps;
	assign res.changed     = res_q.changed;
	assign res.change_low  = res_q.change_low;
	assign res.change_high = res_q.change_high;

endmodule

// ----- rtl/core/led_bar_level_meter_core.sv -----
// Top level of the LED bar level meter: configuration registers, front end,
// queue and lamp logic. Uses lbm_pkg, the three channel interfaces and all lbm_ modules.
//
// Usage: each item on samp carries one unsigned Q0.AMP_BITS amplitude. For each
// accepted item exactly one item appears on res with the lit lamp count, a changed
// flag and the lowest and highest lamp counts that bound the change.
// The cfg channel writes lamp_count (index 0) and fall_step (index 1); it is always
// ready, other indexes are ignored. Write it only while no item is in flight.
// An accepted sample passes the front pipeline, the queue and the result register; the log
// conversion takes one squaring stage per level bit. Throughput is one item per
// cycle while res is ready, since the front end is fully pipelined.
// When res stalls, its output register and the two-entry queue fill and then the
// front pipeline halts, pulling samp.ready low; nothing is dropped.
// Reset clears the shown level and the lamp count to zero and loads lamp_count 16
// and fall_step 3932; no clearing pass follows.
module led_bar_level_meter_core import lbm_pkg::*; #(
	parameter int MAX_LAMPS  = 24,
	parameter int AMP_BITS   = 24,
	parameter int LEVEL_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	lbm_samp_if.sink  samp,
	lbm_cfg_if.sink   cfg,
	lbm_res_if.source res
);

	logic [LAMP_W-1:0] lamp_count_q;
	logic [FALL_W-1:0] fall_step_q;

	logic                  f_valid, f_ready;
	logic [LEVEL_BITS-1:0] f_lvl;
	logic                  b_valid, b_ready;
	logic [LEVEL_BITS-1:0] b_lvl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_count_q <= LAMP_COUNT_RST;
			fall_step_q <= FALL_STEP_RST;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_LAMP_COUNT: begin
					lamp_count_q <= cfg.data[LAMP_W-1:0];
				end
				REG_FALL_STEP: begin
					fall_step_q <= cfg.data[FALL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	lbm_front #(
		.AMP_BITS  (AMP_BITS),
		.LEVEL_BITS(LEVEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.samp     (samp),
		.lvl_valid(f_valid),
		.lvl_ready(f_ready),
		.lvl      (f_lvl)
	);

	lbm_queue #(
		.W(LEVEL_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_lvl),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_lvl)
	);

	lbm_back #(
		.LEVEL_BITS(LEVEL_BITS),
		.MAX_LAMPS (MAX_LAMPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.lvl_valid (b_valid),
		.lvl_ready (b_ready),
		.lvl       (b_lvl),
		.lamp_count(lamp_count_q),
		.fall_step (fall_step_q),
		.res       (res)
	);

endmodule
